>>> design/tlg_pkg.sv
// ----------------------------------------------------------------------------
// tlg_pkg
// Shared types and constants of the toroidal life generation step block.
// ----------------------------------------------------------------------------
package tlg_pkg;

  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam int X_W      = 6;
  localparam int Y_W      = 5;
  localparam int ROW_W    = 64;
  localparam int PERIOD_W = 10;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd10;

  // Register index taken from paddr[2]
  localparam logic REG_STEP_PERIOD = 1'b0;

  // Input item kinds
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  // B3/S23 neighbor counts
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef struct packed {
    logic           is_tick;
    logic           gen;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    logic           value;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CELL_RD,
    ST_CELL_WB,
    ST_RUN
  } back_state_t;

endpackage

>>> design/tlg_front.sv
// ----------------------------------------------------------------------------
// tlg_front
// Accepts requests, drops writes outside the grid, tracks the frame phase and
// tags each tick with whether it computes a generation.
// ----------------------------------------------------------------------------
module tlg_front #(
  parameter int GRID_WIDTH  = tlg_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = tlg_pkg::GRID_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         full,
  input  logic                         mode,
  input  logic [tlg_pkg::X_W-1:0]      cell_x,
  input  logic [tlg_pkg::Y_W-1:0]      cell_y,
  input  logic                         cell_value,
  input  logic [tlg_pkg::PERIOD_W-1:0] step_period,
  output logic                         push,
  output tlg_pkg::cmd_t                cmd
);

  logic [tlg_pkg::PERIOD_W-1:0] frame_phase;
  logic [tlg_pkg::PERIOD_W-1:0] frame_phase_next;
  logic [tlg_pkg::PERIOD_W:0]   phase_inc;
  logic                         accept;
  logic                         in_grid;

  assign accept  = start && !full;
  assign in_grid = (32'(cell_x) < 32'(GRID_WIDTH)) && (32'(cell_y) < 32'(GRID_HEIGHT));

  // Period zero wraps every tick, same as period one
  assign phase_inc = {1'b0, frame_phase} + {{tlg_pkg::PERIOD_W{1'b0}}, 1'b1};
  always_comb begin
    if (phase_inc >= {1'b0, step_period}) begin
      frame_phase_next = '0;
    end else begin
      frame_phase_next = phase_inc[tlg_pkg::PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_phase <= '0;
    end else if (accept && mode == tlg_pkg::MODE_TICK) begin
      frame_phase <= frame_phase_next;
    end
  end

  assign push = accept && (mode == tlg_pkg::MODE_TICK || in_grid);

  always_comb begin
    cmd.is_tick = (mode == tlg_pkg::MODE_TICK);
    cmd.gen     = (frame_phase == '0);
    cmd.x       = cell_x;
    cmd.y       = cell_y;
    cmd.value   = cell_value;
  end

endmodule

>>> design/tlg_queue.sv
// ----------------------------------------------------------------------------
// tlg_queue
// Short FIFO of decoded requests between the front and the back.
// ----------------------------------------------------------------------------
module tlg_queue #(
  parameter int DEPTH = tlg_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tlg_pkg::cmd_t push_cmd,
  input  logic          pop,
  output tlg_pkg::cmd_t pop_cmd,
  output logic          full,
  output logic          empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  tlg_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + CNT_W'(1);
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> design/tlg_back.sv
// ----------------------------------------------------------------------------
// tlg_back
// Holds the grid in a row memory and carries out requests: read-modify-write
// for cell writes, a row sweep for ticks that optionally applies B3/S23.
// ----------------------------------------------------------------------------
module tlg_back #(
  parameter int GRID_WIDTH  = tlg_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = tlg_pkg::GRID_HEIGHT_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      empty,
  input  tlg_pkg::cmd_t             pop_cmd,
  output logic                      pop,
  output logic                      strobe,
  output logic [tlg_pkg::Y_W-1:0]   row_index,
  output logic [tlg_pkg::ROW_W-1:0] row_bits,
  output logic                      last_row
);

  localparam int W     = GRID_WIDTH;
  localparam int H     = GRID_HEIGHT;
  localparam int AW    = $clog2(H);
  localparam int XW    = $clog2(W);
  localparam int CW    = $clog2(H + 3);
  localparam int FIRST_CALC = 3;
  localparam int LAST_STEP  = H + 2;

  tlg_pkg::back_state_t state;
  tlg_pkg::back_state_t state_next;
  tlg_pkg::cmd_t        cmd;

  logic [CW-1:0] cnt;
  logic [W-1:0]  mem [H];
  logic [H-1:0]  row_valid;
  logic [W-1:0]  rd_raw;
  logic          rd_hit;
  logic [W-1:0]  rd_row;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [W-1:0]  wr_data;

  logic [W-1:0]  prev;
  logic [W-1:0]  cur;
  logic [W-1:0]  first;
  logic [W-1:0]  nxt;
  logic [W-1:0]  life_row;
  logic [W-1:0]  emit_row;
  logic [W-1:0]  cell_mask;
  logic [AW-1:0] calc_y;
  logic          calc_step;
  logic          last_step;

  assign last_step = (cnt == CW'(LAST_STEP));
  assign calc_step = (state == tlg_pkg::ST_RUN) && (cnt >= CW'(FIRST_CALC));
  assign calc_y    = AW'(cnt - CW'(FIRST_CALC));
  assign nxt       = last_step ? first : rd_row;
  assign cell_mask = W'(1) << XW'(cmd.x);

  // Next generation of the row between prev and nxt, wrapping at both edges
  for (genvar i = 0; i < W; i++) begin : g_cell
    localparam int L = (i + W - 1) % W;
    localparam int R = (i + 1) % W;
    logic [3:0] n;
    assign n = 4'(prev[L]) + 4'(prev[i]) + 4'(prev[R]) + 4'(cur[L]) + 4'(cur[R])
             + 4'(nxt[L]) + 4'(nxt[i]) + 4'(nxt[R]);
    assign life_row[i] = cur[i] ? (n == tlg_pkg::SURVIVE_COUNT || n == tlg_pkg::BIRTH_COUNT)
                                : (n == tlg_pkg::BIRTH_COUNT);
  end

  assign emit_row = cmd.gen ? life_row : cur;

  // Row memory; rows never written read as dead
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
      rd_hit <= row_valid[rd_addr];
    end
  end

  assign rd_row = rd_hit ? rd_raw : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      tlg_pkg::ST_IDLE: begin
        if (!empty) begin
          state_next = pop_cmd.is_tick ? tlg_pkg::ST_RUN : tlg_pkg::ST_CELL_RD;
        end
      end
      tlg_pkg::ST_CELL_RD: state_next = tlg_pkg::ST_CELL_WB;
      tlg_pkg::ST_CELL_WB: state_next = tlg_pkg::ST_IDLE;
      tlg_pkg::ST_RUN: begin
        if (last_step) begin
          state_next = tlg_pkg::ST_IDLE;
        end
      end
      default: state_next = tlg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (state)
      tlg_pkg::ST_IDLE: begin
        pop = !empty;
      end
      tlg_pkg::ST_CELL_RD: begin
        rd_en   = 1'b1;
        rd_addr = AW'(cmd.y);
      end
      tlg_pkg::ST_CELL_WB: begin
        wr_en   = 1'b1;
        wr_addr = AW'(cmd.y);
        wr_data = cmd.value ? (rd_row | cell_mask) : (rd_row & ~cell_mask);
      end
      tlg_pkg::ST_RUN: begin
        // Read the bottom row first for the wrap, then rows 0 upward
        rd_en   = (cnt <= CW'(H));
        rd_addr = (cnt == '0) ? AW'(H - 1) : AW'(cnt - CW'(1));
        wr_en   = calc_step && cmd.gen;
        wr_addr = calc_y;
        wr_data = life_row;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= pop_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == tlg_pkg::ST_RUN && !last_step) begin
      cnt <= cnt + CW'(1);
    end else begin
      cnt <= '0;
    end
  end

  // Sliding window of old rows; first keeps old row 0 for the final wrap
  always_ff @(posedge clk) begin
    if (state == tlg_pkg::ST_RUN) begin
      if (cnt == CW'(1)) begin
        prev <= rd_row;
      end else if (cnt == CW'(2)) begin
        cur   <= rd_row;
        first <= rd_row;
      end else if (calc_step && !last_step) begin
        prev <= cur;
        cur  <= rd_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= calc_step;
    end
  end

  always_ff @(posedge clk) begin
    row_index <= tlg_pkg::Y_W'(calc_y);
    row_bits  <= tlg_pkg::ROW_W'(emit_row);
    last_row  <= last_step;
  end

endmodule

>>> design/toroidal_life_generation_step.sv
// ----------------------------------------------------------------------------
// toroidal_life_generation_step
// Wrapping B3/S23 life grid with cell writes, frame ticks and a row stream.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; up to two requests
// queue while an earlier one runs. A cell write occupies the row engine for
// a row read and a write-back, a frame tick for a full sweep: the grid lives
// in a single row memory with a registered read, and the engine sweeps it one
// row per cycle, computing the next generation on the fly when the phase is
// zero. Rows come out on consecutive cycles, marked by strobe, rows 0 upward,
// last_row on the final one; there is no way to hold them off, so capture
// each row in the cycle it appears. step_period is written through the APB
// port at address 0; the user must write it only while idle, not enforced here.
module toroidal_life_generation_step #(
  parameter int GRID_WIDTH  = tlg_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = tlg_pkg::GRID_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        mode,
  input  logic [tlg_pkg::X_W-1:0]     cell_x,
  input  logic [tlg_pkg::Y_W-1:0]     cell_y,
  input  logic                        cell_value,
  output logic                        strobe,
  output logic [tlg_pkg::Y_W-1:0]     row_index,
  output logic [tlg_pkg::ROW_W-1:0]   row_bits,
  output logic                        last_row,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tlg_pkg::PADDR_W-1:0] paddr,
  input  logic [tlg_pkg::PDATA_W-1:0] pwdata,
  output logic [tlg_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  logic [tlg_pkg::PERIOD_W-1:0] step_period;
  logic                         push;
  logic                         pop;
  logic                         full;
  logic                         empty;
  tlg_pkg::cmd_t                push_cmd;
  tlg_pkg::cmd_t                pop_cmd;

  assign pready = 1'b1;
  assign busy   = full;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_period <= tlg_pkg::PERIOD_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == tlg_pkg::REG_STEP_PERIOD) begin
      step_period <= pwdata[tlg_pkg::PERIOD_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == tlg_pkg::REG_STEP_PERIOD) begin
      prdata = tlg_pkg::PDATA_W'(step_period);
    end else begin
      prdata = '0;
    end
  end

  tlg_front #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .full       (full),
    .mode       (mode),
    .cell_x     (cell_x),
    .cell_y     (cell_y),
    .cell_value (cell_value),
    .step_period(step_period),
    .push       (push),
    .cmd        (push_cmd)
  );

  tlg_queue #(
    .DEPTH(tlg_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .pop_cmd (pop_cmd),
    .full    (full),
    .empty   (empty)
  );

  tlg_back #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_cmd  (pop_cmd),
    .pop      (pop),
    .strobe   (strobe),
    .row_index(row_index),
    .row_bits (row_bits),
    .last_row (last_row)
  );

endmodule

>>> design/tlg_checker.sv
// ----------------------------------------------------------------------------
// tlg_checker
// Port-level checks on busy and the row stream of the life block, bound to the top.
// ----------------------------------------------------------------------------
module tlg_checker #(
  parameter int GRID_WIDTH  = tlg_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = tlg_pkg::GRID_HEIGHT_DEF
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      busy,
  input logic                      strobe,
  input logic [tlg_pkg::Y_W-1:0]   row_index,
  input logic [tlg_pkg::ROW_W-1:0] row_bits,
  input logic                      last_row
);

  localparam logic [tlg_pkg::Y_W-1:0] LAST_INDEX = tlg_pkg::Y_W'(GRID_HEIGHT - 1);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !strobe && !busy)
    else $error("strobe or busy high right after reset");

  a_rows_in_order: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_row |=> strobe && row_index == $past(row_index) + tlg_pkg::Y_W'(1))
    else $error("row stream broken or out of order");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    strobe && last_row |-> row_index == LAST_INDEX)
    else $error("last_row on wrong row");

  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    strobe && last_row |=> !strobe)
    else $error("row strobe directly after last row");

  a_unused_bits: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (row_bits >> GRID_WIDTH) == '0)
    else $error("row bits set beyond grid width");

endmodule

bind toroidal_life_generation_step tlg_checker #(
  .GRID_WIDTH (GRID_WIDTH),
  .GRID_HEIGHT(GRID_HEIGHT)
) u_tlg_checker (
  .clk      (clk),
  .rst      (rst),
  .busy     (busy),
  .strobe   (strobe),
  .row_index(row_index),
  .row_bits (row_bits),
  .last_row (last_row)
);
